// ----- design/smu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_pkg: shared types and constants of the momentum update block
// Fixed-point widths, register codes, sequencer states and the settings
// clamp and saturation helpers.
// ----------------------------------------------------------------------------
package smu_pkg;

    localparam int IDX_W     = 12;  // element index port
    localparam int DATA_W    = 32;  // Q16.16 parameter, gradient, velocity
    localparam int Q_W       = 17;  // Q0.16 settings, 65536 = 1.0
    localparam int G_W       = 33;  // gradient plus decay term
    localparam int STEP_W    = 34;  // step before learning rate
    localparam int MUL_A_W   = 34;  // multiplier data operand
    localparam int PROD_W    = 36;  // rounded product and wide sums
    localparam int CFG_IDX_W = 3;

    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LR       = 3'd0,
        CFG_MOMENTUM = 3'd1,
        CFG_DAMPEN   = 3'd2,
        CFG_DECAY    = 3'd3,
        CFG_NESTEROV = 3'd4
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECAY,
        ST_GRAD,
        ST_DAMP,
        ST_VMOM,
        ST_VSUM,
        ST_NEST,
        ST_LR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     clip;
    } t_sat;

    // Limit a Q0.16 setting to 1.0.
    function automatic logic [Q_W-1:0] clamp_q16(input logic [Q_W-1:0] s);
        return (s > ONE_Q16) ? ONE_Q16 : s;
    endfunction

    // Saturate a wide signed value to 32 bits and flag the clip.
    function automatic t_sat sat32(input logic signed [PROD_W-1:0] x);
        t_sat r;
        if (x > PROD_W'(signed'(33'sh0_7FFF_FFFF))) begin
            r.value = 32'sh7FFF_FFFF;
            r.clip  = 1'b1;
        end else if (x < PROD_W'(signed'(33'sh1_8000_0000))) begin
            r.value = 32'sh8000_0000;
            r.clip  = 1'b1;
        end else begin
            r.value = x[DATA_W-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- design/smu_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_mul: registered fixed-point scale unit
// Multiplies a signed Q16.16 operand by an unsigned Q0.16 factor and rounds
// half toward plus infinity back to Q16.16; the result is registered.
// ----------------------------------------------------------------------------
module smu_mul import smu_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic        [Q_W-1:0]     i_f,
    output logic signed [PROD_W-1:0]  o_prod
);

    localparam int FULL_W = MUL_A_W + Q_W + 1;

    logic signed [FULL_W-1:0] full;
    logic signed [PROD_W-1:0] r_prod;

    // Add half an LSB, then floor by the arithmetic shift.
    assign full = FULL_W'(i_a) * FULL_W'(signed'({1'b0, i_f}))
                + FULL_W'(signed'(17'sd32768));

    always_ff @(posedge i_clk) begin
        r_prod <= full[FULL_W-1 -: PROD_W];
    end

    assign o_prod = r_prod;

endmodule

// ----- design/smu_vel_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_vel_mem: velocity storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smu_vel_mem import smu_pkg::*; #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [ADDR_W-1:0]        i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sgd_momentum_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_momentum_update: per-element SGD step with momentum and weight decay
// Fixed-point parameter update, classical or look-ahead momentum, with a
// velocity memory of ELEMENTS entries and saturated results.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an element index, parameter and gradient; the item is
//   taken at the edge where start is high and busy is low. busy stays high
//   while the item is worked, and one result comes back on o_upd_param and
//   o_saturated, marked by o_result_valid for exactly one cycle. The
//   receiver cannot stall; the result must be taken in that cycle.
// Sequencing:
//   The sequencer shares one registered multiplier. An item passes the
//   decay step, the gradient step that also reads the velocity memory,
//   then with momentum on the damping, momentum and velocity sum steps
//   and, if selected, the look-ahead step; last the learning-rate and
//   output steps. The next item is taken at the edge ending the strobe.
// Reset:
//   Synchronous, active low. Settings return to their defaults and the
//   velocity memory is swept to zero, one entry per cycle, with busy high
//   up to the last entry. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module sgd_momentum_update import smu_pkg::*; #(
    parameter int ELEMENTS = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [IDX_W-1:0]         i_element_index,
    input  logic signed [DATA_W-1:0] i_param_value,
    input  logic signed [DATA_W-1:0] i_grad_value,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [Q_W-1:0]           i_cfg_wdata,
    output logic                     o_result_valid,
    output logic signed [DATA_W-1:0] o_upd_param,
    output logic                     o_saturated
);

    localparam int ADDR_W  = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    // Reciprocal for the index wrap: quotient estimate is exact or one low.
    localparam int RECIP_SH = 24;
    localparam int RECIP    = (1 << RECIP_SH) / ELEMENTS;
    localparam int QM_W     = IDX_W + RECIP_SH + 1;
    localparam int REM_W    = IDX_W + 21;

    // Sequencer and settings
    t_state           r_state, n_state;
    logic [Q_W-1:0]   r_lr, r_mom, r_damp, r_wd;
    logic             r_nest;
    logic [ADDR_W-1:0] r_clr_addr;
    logic             r_res_valid;

    // Item payload
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_quot;
    logic [ADDR_W-1:0]        r_addr;
    logic signed [DATA_W-1:0] r_param;
    logic signed [DATA_W-1:0] r_grad;
    logic signed [G_W-1:0]    r_g;
    logic signed [STEP_W-1:0] r_gd;
    logic signed [STEP_W-1:0] r_step;
    logic                     r_clip;
    logic signed [DATA_W-1:0] r_upd_param;
    logic                     r_saturated;

    // Combinational
    logic                     accept;
    logic [Q_W-1:0]           lr_c, mom_c, damp_c, wd_c, keep_c;
    logic                     mom_on;
    logic [QM_W-1:0]          quot_full;
    logic [REM_W-1:0]         rem;
    logic [ADDR_W-1:0]        addr_mod;
    logic signed [G_W-1:0]    g_sum;
    t_sat                     v_sat;
    t_sat                     res_sat;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [Q_W-1:0]           mul_f;
    logic signed [PROD_W-1:0] prod;
    logic                     mem_we, mem_re;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic signed [DATA_W-1:0] mem_rdata;

    assign accept = start && !busy;

    assign lr_c   = clamp_q16(r_lr);
    assign mom_c  = clamp_q16(r_mom);
    assign damp_c = clamp_q16(r_damp);
    assign wd_c   = clamp_q16(r_wd);
    assign keep_c = ONE_Q16 - damp_c;
    assign mom_on = (mom_c != '0);

    // Wrap the index into the store: estimate, then one correction.
    assign quot_full = (QM_W'(i_element_index) * QM_W'(RECIP)) >> RECIP_SH;

    always_comb begin
        rem = REM_W'(r_idx) - REM_W'(r_quot) * REM_W'(ELEMENTS);
        if (rem >= REM_W'(ELEMENTS)) begin
            rem = rem - REM_W'(ELEMENTS);
        end
        addr_mod = rem[ADDR_W-1:0];
    end

    assign g_sum   = G_W'(r_grad) + prod[G_W-1:0];
    assign v_sat   = sat32(PROD_W'(r_gd) + prod);
    assign res_sat = sat32(PROD_W'(r_param) - prod);

    smu_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_f    (mul_f),
        .o_prod (prod)
    );

    smu_vel_mem #(
        .DEPTH  (ELEMENTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(ELEMENTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECAY;
                end
            end
            ST_DECAY: n_state = ST_GRAD;
            ST_GRAD:  n_state = mom_on ? ST_DAMP : ST_LR;
            ST_DAMP:  n_state = ST_VMOM;
            ST_VMOM:  n_state = ST_VSUM;
            ST_VSUM:  n_state = r_nest ? ST_NEST : ST_LR;
            ST_NEST:  n_state = ST_LR;
            ST_LR:    n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs: multiplier operands and memory strobes
    always_comb begin
        busy      = 1'b1;
        mul_a     = '0;
        mul_f     = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = v_sat.value;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_DECAY: begin
                mul_a = MUL_A_W'(r_param);
                mul_f = wd_c;
            end
            ST_GRAD: begin
                mem_re = 1'b1;
            end
            ST_DAMP: begin
                mul_a = MUL_A_W'(r_g);
                mul_f = keep_c;
            end
            ST_VMOM: begin
                mul_a = MUL_A_W'(mem_rdata);
                mul_f = mom_c;
            end
            ST_VSUM: begin
                mul_a  = MUL_A_W'(v_sat.value);
                mul_f  = mom_c;
                mem_we = 1'b1;
            end
            ST_NEST: begin
            end
            ST_LR: begin
                mul_a = r_step;
                mul_f = lr_c;
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Control and settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
            r_lr        <= Q_W'(655);
            r_mom       <= '0;
            r_damp      <= '0;
            r_wd        <= '0;
            r_nest      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= (r_state == ST_OUT);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LR:       r_lr   <= i_cfg_wdata;
                    CFG_MOMENTUM: r_mom  <= i_cfg_wdata;
                    CFG_DAMPEN:   r_damp <= i_cfg_wdata;
                    CFG_DECAY:    r_wd   <= i_cfg_wdata;
                    CFG_NESTEROV: r_nest <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Item datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx   <= i_element_index;
            r_quot  <= quot_full[IDX_W-1:0];
            r_param <= i_param_value;
            r_grad  <= i_grad_value;
            r_clip  <= 1'b0;
        end
        case (r_state)
            ST_DECAY: r_addr <= addr_mod;
            ST_GRAD: begin
                // Hold the plain step in case momentum is off.
                r_g    <= g_sum;
                r_step <= STEP_W'(g_sum);
            end
            ST_VMOM: r_gd <= prod[STEP_W-1:0];
            ST_VSUM: begin
                r_step <= STEP_W'(v_sat.value);
                r_clip <= v_sat.clip;
            end
            ST_NEST: r_step <= STEP_W'(r_g) + prod[STEP_W-1:0];
            ST_OUT: begin
                r_upd_param <= res_sat.value;
                r_saturated <= r_clip | res_sat.clip;
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_upd_param    = r_upd_param;
    assign o_saturated    = r_saturated;

    // Checks
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_strobe_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_OUT))
        else $error("result strobe without a finished item");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (busy && r_state == ST_CLEAR))
        else $error("velocity sweep not started after reset");

    a_write_needs_momentum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != ST_CLEAR) |-> mom_on)
        else $error("velocity written with momentum off");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!mem_we && !busy))
        else $error("memory written or busy while idle");

endmodule
